// ===== rtl/rmf_pkg.sv =====
`timescale 1ns / 1ps
package rmf_pkg;
    localparam int MAX_WIDTH = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int WINDOW_SIZE = 3;
    localparam int WIN_N = WINDOW_SIZE * WINDOW_SIZE;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DIM_W = COL_W + 1;
    localparam int HDIM_W = ROW_W + 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int PIX_W = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    typedef struct packed {
        logic             emit;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pix;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0] w_m1;
        logic [ROW_W-1:0] h_m1;
    } geom_t;

    function automatic logic [7:0] med9(input logic [WIN_N*8-1:0] v);
        logic [7:0] a [WIN_N];
        logic [7:0] t;
        for (int i = 0; i < WIN_N; i++) a[i] = v[i*8 +: 8];
        for (int p = 0; p < WIN_N; p++)
            for (int i = (p % 2); i + 1 < WIN_N; i = i + 2)
                if (a[i] > a[i+1])
                begin
                    t = a[i];
                    a[i] = a[i+1];
                    a[i+1] = t;
                end
        return a[WIN_N/2];
    endfunction
endpackage

// ===== rtl/rmf_front.sv =====
`timescale 1ns / 1ps
module rmf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic [7:0]                 in_red,
    input  logic [7:0]                 in_green,
    input  logic [7:0]                 in_blue,
    output logic                       q_valid,
    input  logic                       q_ready,
    output rmf_pkg::cmd_t              q_cmd,
    output rmf_pkg::geom_t             geom
);
    import rmf_pkg::*;
    logic [CFG_DATA_W-1:0] w_reg, h_reg;
    logic [COL_W-1:0] lcol_reg, ecol_reg;
    logic [ROW_W-1:0] lrow_reg, erow_reg;
    logic loaded_reg;
    cmd_t q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0] cnt_reg;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic acc, push, pop, lend_c, lend_r, eend_c, eend_r;
    cmd_t c;

    always_comb
    begin
        if (w_reg == '0) wm1 = '0;
        else if (w_reg > CFG_DATA_W'(MAX_WIDTH)) wm1 = COL_W'(MAX_WIDTH - 1);
        else wm1 = COL_W'(w_reg - 1'b1);
        if (h_reg == '0) hm1 = '0;
        else if (h_reg > CFG_DATA_W'(MAX_HEIGHT)) hm1 = ROW_W'(MAX_HEIGHT - 1);
        else hm1 = ROW_W'(h_reg - 1'b1);
    end
    assign geom = '{w_m1: wm1, h_m1: hm1};
    assign cfg_ready = 1'b1;
    assign in_ready = cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign acc = in_valid && in_ready;
    assign lend_c = lcol_reg == wm1;
    assign lend_r = lrow_reg == hm1;
    assign eend_c = ecol_reg == wm1;
    assign eend_r = erow_reg == hm1;
    assign push = acc && (func == FUNC_LOAD || loaded_reg);
    assign pop = q_valid && q_ready;
    assign q_valid = cnt_reg != '0;
    assign q_cmd = q_reg[rp_reg];

    always_comb
    begin
        c.emit = func;
        c.pix = {in_blue, in_green, in_red};
        if (func == FUNC_LOAD)
        begin
            c.col = lcol_reg;
            c.row = lrow_reg;
            c.last = 1'b0;
        end
        else
        begin
            c.col = ecol_reg;
            c.row = erow_reg;
            c.last = eend_c && eend_r;
        end
    end

    always_ff @(posedge clk)
        if (push) q_reg[wp_reg] <= c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= CFG_DATA_W'(256);
            h_reg <= CFG_DATA_W'(256);
            lcol_reg <= '0;
            lrow_reg <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
            loaded_reg <= 1'b0;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
            if (cfg_valid)
            begin
                if (cfg_index == REG_WIDTH) w_reg <= cfg_data;
                else h_reg <= cfg_data;
                lcol_reg <= '0;
                lrow_reg <= '0;
                ecol_reg <= '0;
                erow_reg <= '0;
                loaded_reg <= 1'b0;
            end
            else if (acc && func == FUNC_LOAD)
            begin
                if (lcol_reg == '0 && lrow_reg == '0)
                begin
                    loaded_reg <= 1'b0;
                    ecol_reg <= '0;
                    erow_reg <= '0;
                end
                if (lend_c)
                begin
                    lcol_reg <= '0;
                    if (lend_r)
                    begin
                        lrow_reg <= '0;
                        loaded_reg <= 1'b1;
                    end
                    else lrow_reg <= lrow_reg + 1'b1;
                end
                else lcol_reg <= lcol_reg + 1'b1;
            end
            else if (push)
            begin
                if (eend_c)
                begin
                    ecol_reg <= '0;
                    erow_reg <= eend_r ? '0 : erow_reg + 1'b1;
                end
                else ecol_reg <= ecol_reg + 1'b1;
            end
        end
    end
endmodule

// ===== rtl/rmf_back.sv =====
`timescale 1ns / 1ps
module rmf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  rmf_pkg::cmd_t  q_cmd,
    input  rmf_pkg::geom_t geom,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_red,
    output logic [7:0]     out_green,
    output logic [7:0]     out_blue,
    output logic           last_pixel
);
    import rmf_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;
    logic [PIX_W-1:0] mem [1 << ADDR_W];
    logic [PIX_W-1:0] rd_reg;
    logic [1:0] state_reg;
    logic [3:0] k_reg;
    logic [1:0] du_reg, dv_reg;
    logic [COL_W-1:0] col_reg, rcol_reg;
    logic [ROW_W-1:0] row_reg, rrow_reg;
    logic last_reg;
    logic [WIN_N*8-1:0] r_reg, g_reg, b_reg;
    logic [7:0] or_reg, og_reg, ob_reg;
    logic [COL_W-1:0] cc;
    logic [ROW_W-1:0] rr;
    logic rd_en, cap, start;

    assign q_ready = state_reg == S_IDLE;
    assign start = q_valid && q_ready;
    assign rd_en = state_reg == S_READ;
    assign cap = (state_reg == S_READ && k_reg != '0) || state_reg == S_LAST;

    always_comb
    begin
        unique case (dv_reg)
            2'd0: cc = (col_reg == '0) ? geom.w_m1 : col_reg - 1'b1;
            2'd1: cc = col_reg;
            default: cc = (col_reg == geom.w_m1) ? '0 : col_reg + 1'b1;
        endcase
        unique case (du_reg)
            2'd0: rr = (row_reg == '0) ? geom.h_m1 : row_reg - 1'b1;
            2'd1: rr = row_reg;
            default: rr = (row_reg == geom.h_m1) ? '0 : row_reg + 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start && !q_cmd.emit)
            mem[{q_cmd.row, q_cmd.col}] <= q_cmd.pix;
        if (rd_en) rd_reg <= mem[{rrow_reg, rcol_reg}];
    end

    always_ff @(posedge clk)
    begin
        rrow_reg <= rr;
        rcol_reg <= cc;
        if (cap)
        begin
            r_reg <= {r_reg[WIN_N*8-9:0], rd_reg[7:0]};
            g_reg <= {g_reg[WIN_N*8-9:0], rd_reg[15:8]};
            b_reg <= {b_reg[WIN_N*8-9:0], rd_reg[23:16]};
        end
        if (start)
        begin
            col_reg <= q_cmd.col;
            row_reg <= q_cmd.row;
            last_reg <= q_cmd.last;
        end
        if (state_reg == S_LAST)
        begin
            or_reg <= med9({r_reg[WIN_N*8-9:0], rd_reg[7:0]});
            og_reg <= med9({g_reg[WIN_N*8-9:0], rd_reg[15:8]});
            ob_reg <= med9({b_reg[WIN_N*8-9:0], rd_reg[23:16]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= '0;
            du_reg <= '0;
            dv_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    du_reg <= '0;
                    dv_reg <= '0;
                    k_reg <= '0;
                    if (start && q_cmd.emit) state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (dv_reg == 2'd2)
                    begin
                        dv_reg <= '0;
                        du_reg <= du_reg + 1'b1;
                    end
                    else dv_reg <= dv_reg + 1'b1;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 4'(WIN_N)) state_reg <= S_LAST;
                end
                S_LAST: state_reg <= S_OUT;
                default: if (out_ready) state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = state_reg == S_OUT;
    assign out_red = or_reg;
    assign out_green = og_reg;
    assign out_blue = ob_reg;
    assign last_pixel = last_reg;
endmodule

// ===== rtl/rgb_median_filter_3x3_wrap.sv =====
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_ready   | func, in_red, in_green, in_blue
// out     | out       | out_valid/out_ready | out_red, out_green, out_blue, last_pixel
// a load word is written into the frame store when the back end takes it; an emit runs as
// one address setup, nine reads from the store, the median and the output
// a two-word queue lets the input side keep accepting while the store port is busy
// reset clears positions and sets both dimensions to 256; the store is not cleared
`timescale 1ns / 1ps
module rgb_median_filter_3x3_wrap (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [7:0]                     in_red,
    input  logic [7:0]                     in_green,
    input  logic [7:0]                     in_blue,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_red,
    output logic [7:0]                     out_green,
    output logic [7:0]                     out_blue,
    output logic                           last_pixel
);
    import rmf_pkg::*;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    geom_t geom;

    rmf_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .func, .in_red, .in_green, .in_blue,
        .q_valid, .q_ready, .q_cmd, .geom
    );

    rmf_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .geom,
        .out_valid, .out_ready, .out_red, .out_green, .out_blue, .last_pixel
    );
endmodule

// ===== rtl/rmf_checker.sv =====
`timescale 1ns / 1ps
module rmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic       last_pixel,
    input logic       cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red))
        else $error("output word dropped while stalled");
    a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("results closer than the read sequence allows");
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(last_pixel))
        else $error("last flag changed while stalled");
endmodule

bind rgb_median_filter_3x3_wrap rmf_checker u_rmf_checker (
    .clk, .rst_n, .out_valid, .out_ready, .out_red, .last_pixel, .cfg_ready
);
